// ===== sv/grm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types, constants and the sine table for the grid ray caster.
// ----------------------------------------------------------------------------
package grm_pkg;

    // geometry and screen constants
    localparam int C_MAP_BITS  = 6;
    localparam int C_MAP_CELLS = 4096;
    localparam int C_RAYS      = 320;
    localparam int C_SCREEN_W  = 320;
    localparam int C_SCREEN_H  = 200;
    localparam int C_STEP_SH   = 4;           // step length 16/256 cell
    localparam int C_WALL_NUM  = 200 * 65536; // wall scale in Q16
    localparam int C_DIV_BITS  = 24;
    localparam int C_INV15     = 4369;        // floor(65536/15)

    // configuration register indexes
    localparam logic [1:0] CFG_PLAYER_X   = 2'd0;
    localparam logic [1:0] CFG_PLAYER_Y   = 2'd1;
    localparam logic [1:0] CFG_VIEW_ANGLE = 2'd2;

    // item commands
    localparam logic CMD_MAP_WRITE = 1'b0;
    localparam logic CMD_CAST      = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ANG_MUL,
        S_ANG_FIX,
        S_TRIG,
        S_INIT,
        S_MARCH,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic ang_mul;
        logic ang_fix;
        logic trig;
        logic init;
        logic march;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic cast_ok;
        logic stop;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

    // quarter-wave sine, Q14
    function automatic logic [14:0] quarter_tab(input logic [6:0] i);
        logic [14:0] v;
        begin
            case (i)
                7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
                7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
                7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
                7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
                7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
                7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
                7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
                7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
                7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
                7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
                7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
                7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
                7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
                7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
                7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
                7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
                7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
                7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
                7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
                7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
                7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
                7'd63: v = 15'd16379;
                default: v = 15'd16384;
            endcase
            return v;
        end
    endfunction

    // interpolated quarter lookup, u in 0..16384
    function automatic logic [14:0] quarter_lookup(input logic [14:0] u);
        logic [6:0]  i;
        logic [7:0]  f;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [16:0] prod;
        begin
            i    = u[14:8];
            f    = u[7:0];
            lo   = quarter_tab(i);
            hi   = quarter_tab(i + 7'd1);
            prod = 17'((hi - lo) & 15'h1FF) * 17'(f);
            if (i >= 7'd64) return 15'd16384;
            return lo + 15'(prod[16:8]);
        end
    endfunction

    // full-turn sine, Q14 signed
    function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
        logic [14:0] u;
        logic [14:0] v;
        begin
            u = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
            v = quarter_lookup(u);
            return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
        end
    endfunction

endpackage

// ===== sv/grid_ray_march_column.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_column
// Fixed-step grid ray caster producing one wall column per cast item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): cmd 0 writes one wall bit of
//   the 64x64 map and yields nothing; cmd 1 casts ray i_ray_number and
//   yields one item on the output channel (o_out_valid / i_out_ready).
//   Ray numbers of 320 or more give no result.
//   Config port: i_cfg_we with i_cfg_index 0 = player x, 1 = player y,
//   2 = view angle; write only while the block is idle.
//   Sequence: a map write is stored as it is accepted. A cast runs the
//   ANG_MUL, ANG_FIX, TRIG and INIT setup states, one march step per
//   cycle (up to about 1450 steps), the divider and a load state; the
//   march loop over the map RAM sets the rate.
//   Reset: the map is swept to open floor, all 4096 cells, after reset;
//   no item is taken meanwhile. Config regs and o_out_valid reset to 0.
//   Stall: a result sits in the output register; the next item is taken
//   meanwhile and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module grid_ray_march_column (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_cell_wall,
    input  logic [8:0]  i_ray_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_hit_distance,
    output logic [8:0]  o_screen_column,
    output logic [7:0]  o_column_top,
    output logic [7:0]  o_column_bottom,
    output logic        o_left_map
);

    grm_pkg::t_dp_cmd dp_cmd;
    grm_pkg::t_dp_sts dp_sts;

    grm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    grm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_cell_row      (i_cell_row),
        .i_cell_col      (i_cell_col),
        .i_cell_wall     (i_cell_wall),
        .i_ray_number    (i_ray_number),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_hit_distance  (o_hit_distance),
        .o_screen_column (o_screen_column),
        .o_column_top    (o_column_top),
        .o_column_bottom (o_column_bottom),
        .o_left_map      (o_left_map),
        .i_dp_cmd        (dp_cmd),
        .o_sts           (dp_sts)
    );

endmodule

// ===== sv/grm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/grm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_ctrl
// Sequencer: map clear, item accept, angle setup, march, divide, result load.
// ----------------------------------------------------------------------------
module grm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  grm_pkg::t_dp_sts  i_sts,
    output grm_pkg::t_dp_cmd  o_cmd
);

    grm_pkg::t_state r_state;
    grm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grm_pkg::S_CLEAR:   if (i_sts.clear_done) n_state = grm_pkg::S_IDLE;
            grm_pkg::S_IDLE:    if (i_in_valid && i_sts.cast_ok) n_state = grm_pkg::S_ANG_MUL;
            grm_pkg::S_ANG_MUL: n_state = grm_pkg::S_ANG_FIX;
            grm_pkg::S_ANG_FIX: n_state = grm_pkg::S_TRIG;
            grm_pkg::S_TRIG:    n_state = grm_pkg::S_INIT;
            grm_pkg::S_INIT:    n_state = grm_pkg::S_MARCH;
            grm_pkg::S_MARCH:   if (i_sts.stop) n_state = grm_pkg::S_DIV;
            grm_pkg::S_DIV:     if (i_sts.div_done) n_state = grm_pkg::S_FIN;
            grm_pkg::S_FIN:     if (!i_sts.out_busy) n_state = grm_pkg::S_IDLE;
            default:            n_state = grm_pkg::S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            grm_pkg::S_CLEAR:   o_cmd.clear = 1'b1;
            grm_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            grm_pkg::S_ANG_MUL: o_cmd.ang_mul = 1'b1;
            grm_pkg::S_ANG_FIX: o_cmd.ang_fix = 1'b1;
            grm_pkg::S_TRIG:    o_cmd.trig = 1'b1;
            grm_pkg::S_INIT:    o_cmd.init = 1'b1;
            grm_pkg::S_MARCH:   o_cmd.march = 1'b1;
            grm_pkg::S_DIV:     o_cmd.div_step = 1'b1;
            grm_pkg::S_FIN:     o_cmd.load_out = !i_sts.out_busy;
            default:            o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/grm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_dp
// Datapath: config registers, wall map, ray stepper, divider, output register.
// ----------------------------------------------------------------------------
module grm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_cmd,
    input  logic [5:0]       i_cell_row,
    input  logic [5:0]       i_cell_col,
    input  logic             i_cell_wall,
    input  logic [8:0]       i_ray_number,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [14:0]      o_hit_distance,
    output logic [8:0]       o_screen_column,
    output logic [7:0]       o_column_top,
    output logic [7:0]       o_column_bottom,
    output logic             o_left_map,
    input  grm_pkg::t_dp_cmd i_dp_cmd,
    output grm_pkg::t_dp_sts o_sts
);

    // configuration
    logic [13:0] r_px;
    logic [13:0] r_py;
    logic [15:0] r_view;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_view <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                grm_pkg::CFG_PLAYER_X:   r_px   <= i_cfg_data[13:0];
                grm_pkg::CFG_PLAYER_Y:   r_py   <= i_cfg_data[13:0];
                grm_pkg::CFG_VIEW_ANGLE: r_view <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // map clear sweep
    logic [11:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_dp_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 12'd1;
        end
    end

    // wall map
    logic        map_we;
    logic [11:0] map_waddr;
    logic        map_wdata;
    logic [11:0] map_raddr;
    logic        map_rdata;

    assign map_we    = i_dp_cmd.clear ||
                       (i_dp_cmd.accept && i_cmd == grm_pkg::CMD_MAP_WRITE);
    assign map_waddr = i_dp_cmd.clear ? r_clr_addr : {i_cell_row, i_cell_col};
    assign map_wdata = i_dp_cmd.clear ? 1'b0 : i_cell_wall;

    grm_ram #(
        .WIDTH (1),
        .DEPTH (grm_pkg::C_MAP_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // ray angle: view + floor((2*ray + 11*RAYS)*256/15)
    logic [8:0]  r_ray;
    logic [12:0] ang_m;
    logic [25:0] ang_prod;
    logic [8:0]  r_aest;
    logic [12:0] ang_rem;
    logic [8:0]  ang_a;
    logic [3:0]  ang_b;
    logic [15:0] r_ang;

    assign ang_m    = {3'b0, r_ray, 1'b0} + 13'(11 * grm_pkg::C_RAYS);
    assign ang_prod = 26'(ang_m) * 26'(grm_pkg::C_INV15);
    assign ang_rem  = ang_m - 13'(r_aest) * 13'd15;

    always_comb begin
        if (ang_rem >= 13'd15) begin
            ang_a = r_aest + 9'd1;
            ang_b = 4'(ang_rem - 13'd15);
        end else begin
            ang_a = r_aest;
            ang_b = ang_rem[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) r_ray <= i_ray_number;
        if (i_dp_cmd.ang_mul) r_aest <= ang_prod[24:16];
        if (i_dp_cmd.ang_fix) begin
            r_ang <= r_view + {ang_a[7:0], 8'b0} + 16'(ang_b * 8'd17);
        end
    end

    // step vector, units of 2^-24 cell
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.trig) begin
            r_dx <= 32'(grm_pkg::sine_q14(r_ang + 16'h4000)) <<< (2 + grm_pkg::C_STEP_SH);
            r_dy <= -(32'(grm_pkg::sine_q14(r_ang)) <<< (2 + grm_pkg::C_STEP_SH));
        end
    end

    // march
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [11:0]        r_steps;
    logic               outside;
    logic [15:0]        dist_raw;

    assign nx = (i_dp_cmd.init ? $signed({2'b0, r_px, 16'b0}) : r_x) + r_dx;
    assign ny = (i_dp_cmd.init ? $signed({2'b0, r_py, 16'b0}) : r_y) + r_dy;
    assign map_raddr = {ny[29:24], nx[29:24]};
    assign outside   = r_x[31] | r_x[30] | r_y[31] | r_y[30];
    assign o_sts.stop = outside | map_rdata;
    assign dist_raw  = {r_steps, 4'b0};

    // divider: wall scale / distance, restoring, one bit a cycle
    logic [14:0] r_dist;
    logic        r_left;
    logic [14:0] r_rem;
    logic [23:0] r_quo;
    logic [4:0]  r_div_cnt;
    logic [15:0] div_tmp;
    logic        div_ge;

    assign div_tmp = {r_rem, r_quo[23]};
    assign div_ge  = div_tmp >= {1'b0, r_dist};

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.init) begin
            r_x     <= nx;
            r_y     <= ny;
            r_steps <= 12'd1;
        end else if (i_dp_cmd.march) begin
            if (o_sts.stop) begin
                r_left    <= outside;
                r_dist    <= dist_raw[15] ? 15'h7FFF : dist_raw[14:0];
                r_rem     <= '0;
                r_quo     <= 24'(grm_pkg::C_WALL_NUM);
                r_div_cnt <= '0;
            end else begin
                r_x     <= nx;
                r_y     <= ny;
                r_steps <= r_steps + 12'd1;
            end
        end else if (i_dp_cmd.div_step) begin
            r_rem     <= div_ge ? 15'(div_tmp - {1'b0, r_dist}) : div_tmp[14:0];
            r_quo     <= {r_quo[22:0], div_ge};
            r_div_cnt <= r_div_cnt + 5'd1;
        end
    end

    // column rows from height
    logic [18:0]        half;
    logic signed [21:0] start;
    logic signed [21:0] last;
    logic [7:0]         top;
    logic [7:0]         bottom;

    assign half  = r_quo[19:1];
    assign start = 22'sd25600 - $signed({3'b0, half});
    assign last  = start + $signed({2'b0, half[18:7], 8'b0});
    assign top   = start[21] ? 8'd0 : start[15:8];
    assign bottom = (last[20:8] > 13'(grm_pkg::C_SCREEN_H - 1)) ?
                    8'(grm_pkg::C_SCREEN_H - 1) : last[15:8];

    // output register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_out) begin
            o_hit_distance  <= r_dist;
            o_screen_column <= 9'(grm_pkg::C_SCREEN_W - 1) - r_ray;
            o_column_top    <= top;
            o_column_bottom <= bottom;
            o_left_map      <= r_left;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.clear_done = (r_clr_addr == 12'(grm_pkg::C_MAP_CELLS - 1));
    assign o_sts.cast_ok    = (i_cmd == grm_pkg::CMD_CAST) &&
                              (i_ray_number < 9'(grm_pkg::C_RAYS));
    assign o_sts.div_done   = (r_div_cnt == 5'(grm_pkg::C_DIV_BITS - 1));
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

endmodule
